/* rtl/gcsq_pkg.sv */
// Shared types, codes and token helpers for the G-code command splitter queue.
// Used by gcode_command_splitter_queue; no dependencies.

package gcsq_pkg;

    // Default configuration
    localparam int unsigned DEF_RING_ENTRIES = 16;
    localparam int unsigned DEF_TOKENS_PER_CMD = 8;
    localparam int unsigned DEF_TOKEN_CHARS = 8;

    // Fixed field widths
    localparam int unsigned MODE_W = 2;
    localparam int unsigned TEXT_W = 64;
    localparam int unsigned TOK_W = 56;
    localparam int unsigned TYPE_W = 5;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned IDX_W = 3;
    localparam int unsigned TOTAL_W = 4;
    localparam int unsigned COUNT_W = 5;

    // Request modes
    typedef enum logic [MODE_W-1:0] {
        MODE_TOKEN = 2'd0,
        MODE_EOL   = 2'd1,
        MODE_POP   = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_EOL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TOKEN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    // Control sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH,
        S_PUSH_LAST,
        S_REPORT,
        S_POP_META,
        S_POP
    } t_state;

    // Number scan phases
    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } t_scan;

    // ASCII codes
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_M = 8'h4D;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_CASE_GAP = 8'h20;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [10:0] NUM_CEIL = 11'd1000;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ? c - CHAR_CASE_GAP : c;
    endfunction

    function automatic logic is_cmd_letter(input logic [7:0] c);
        logic [7:0] u;
        u = to_upper(c);
        return (u == CHAR_G) || (u == CHAR_M);
    endfunction

    // Keep the leading characters up to the first NUL, at most lim of them
    function automatic logic [TOK_W-1:0] stored_form(input logic [TEXT_W-1:0] text,
                                                     input int unsigned lim);
        logic [TOK_W-1:0] r;
        logic run;
        r = '0;
        run = 1'b1;
        for (int i = 0; i < TOK_W / 8; i++) begin
            if (run && i < lim && text[8*i +: 8] != 8'h00) begin
                r[8*i +: 8] = text[8*i +: 8];
            end else begin
                run = 1'b0;
            end
        end
        return r;
    endfunction

    // Dense command code from letter and signed decimal number
    function automatic logic [TYPE_W-1:0] classify(input logic [TEXT_W-1:0] text);
        logic [7:0] first;
        logic [7:0] c;
        t_scan phase;
        logic neg;
        logic seen;
        logic dig;
        logic take;
        logic [1:0] nsig;
        logic [3:0] hi;
        logic [3:0] lo;
        logic [6:0] val;
        logic [TYPE_W-1:0] code;
        first = to_upper(text[7:0]);
        phase = PH_SPACE;
        neg = 1'b0;
        seen = 1'b0;
        nsig = 2'd0;
        hi = '0;
        lo = '0;
        code = '0;
        for (int i = 1; i < TEXT_W / 8; i++) begin
            c = text[8*i +: 8];
            dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            take = 1'b0;
            case (phase)
                PH_SPACE: begin
                    if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
                        phase = PH_SPACE;
                    end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                        neg = (c == CHAR_MINUS);
                        phase = PH_SIGN;
                    end else if (dig) begin
                        take = 1'b1;
                        phase = PH_DIGITS;
                    end else begin
                        phase = PH_DONE;
                    end
                end
                PH_SIGN, PH_DIGITS: begin
                    if (dig) begin
                        take = 1'b1;
                        phase = PH_DIGITS;
                    end else begin
                        phase = PH_DONE;
                    end
                end
                default: begin
                    phase = PH_DONE;
                end
            endcase
            // Skip leading zeros, hold two significant digits; a third means out of range
            if (take) begin
                seen = 1'b1;
                if (nsig == 2'd0) begin
                    if (c != CHAR_ZERO) begin
                        hi = c[3:0];
                        nsig = 2'd1;
                    end
                end else if (nsig == 2'd1) begin
                    lo = c[3:0];
                    nsig = 2'd2;
                end else begin
                    nsig = 2'd3;
                end
            end
        end
        val = (nsig == 2'd2) ? 7'(hi) * 7'd10 + 7'(lo) : 7'(hi);
        if (seen && nsig != 2'd3 && !(neg && nsig != 2'd0)) begin
            if (first == CHAR_G) begin
                case (val)
                    7'd0:  code = 5'd1;
                    7'd1:  code = 5'd2;
                    7'd2:  code = 5'd3;
                    7'd3:  code = 5'd4;
                    7'd4:  code = 5'd5;
                    7'd17: code = 5'd6;
                    7'd18: code = 5'd7;
                    7'd19: code = 5'd8;
                    7'd20: code = 5'd9;
                    7'd21: code = 5'd10;
                    7'd28: code = 5'd11;
                    7'd30: code = 5'd12;
                    7'd90: code = 5'd13;
                    7'd91: code = 5'd14;
                    7'd92: code = 5'd15;
                    default: code = '0;
                endcase
            end else if (first == CHAR_M) begin
                case (val)
                    7'd0:  code = 5'd16;
                    7'd1:  code = 5'd17;
                    7'd2:  code = 5'd18;
                    7'd3:  code = 5'd19;
                    7'd4:  code = 5'd20;
                    7'd5:  code = 5'd21;
                    7'd7:  code = 5'd22;
                    7'd8:  code = 5'd23;
                    7'd9:  code = 5'd24;
                    7'd30: code = 5'd25;
                    default: code = '0;
                endcase
            end
        end
        return code;
    endfunction

endpackage

/* rtl/gcsq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module gcsq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/gcode_command_splitter_queue.sv */
// Top level of the G-code command splitter queue: sequencer and queue pointers.
// Depends on gcsq_pkg and gcsq_ram (open command, ring header, ring token store).
//
// Channel  | Direction | Handshake                   | Payload
// request  | in        | start, busy (taken: !busy)  | i_mode, i_token_text
// result   | out       | o_valid strobe, no stall    | o_kind .. o_queue_fill
//
// Steps: S_DECODE decodes each request. A command letter that closes an open command
// copies its n tokens from the open buffer into the ring store in S_PUSH, one token per
// cycle through the store write port, and writes the header in S_PUSH_LAST. End of line
// does the same when it pushes, then reports in S_REPORT. A pop reads the header in
// S_POP_META, then strobes one result per cycle, paced by the token store read port.
// Reset clears the pointers, fill level and line state; the memories keep no
// reset value. Results are strobed one cycle each and cannot be held off.

module gcode_command_splitter_queue #(
    parameter int unsigned RING_ENTRIES = gcsq_pkg::DEF_RING_ENTRIES,
    parameter int unsigned TOKENS_PER_COMMAND = gcsq_pkg::DEF_TOKENS_PER_CMD,
    parameter int unsigned TOKEN_CHARS = gcsq_pkg::DEF_TOKEN_CHARS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [gcsq_pkg::MODE_W-1:0]    i_mode,
    input  logic [gcsq_pkg::TEXT_W-1:0]    i_token_text,
    output logic                           o_valid,
    output logic [gcsq_pkg::KIND_W-1:0]    o_kind,
    output logic [gcsq_pkg::TYPE_W-1:0]    o_cmd_type,
    output logic [gcsq_pkg::TOK_W-1:0]     o_token_out,
    output logic [gcsq_pkg::IDX_W-1:0]     o_token_index,
    output logic [gcsq_pkg::TOTAL_W-1:0]   o_tokens_in_command,
    output logic                           o_last,
    output logic [gcsq_pkg::COUNT_W-1:0]   o_added_in_line,
    output logic [gcsq_pkg::COUNT_W-1:0]   o_queue_fill
);

    import gcsq_pkg::*;

    localparam int unsigned SW = $clog2(RING_ENTRIES);
    localparam int unsigned FW = $clog2(RING_ENTRIES + 1);
    localparam int unsigned CW = $clog2(TOKENS_PER_COMMAND + 1);
    localparam int unsigned OIW = (TOKENS_PER_COMMAND > 1) ? $clog2(TOKENS_PER_COMMAND) : 1;
    localparam int unsigned STORE_DEPTH = RING_ENTRIES * TOKENS_PER_COMMAND;
    localparam int unsigned AW = $clog2(STORE_DEPTH);
    localparam int unsigned MW = TYPE_W + CW;
    localparam logic [TEXT_W-1:0] TEXT_MASK = {TEXT_W{1'b1}} >> (TEXT_W - 8 * TOKEN_CHARS);

    // Sequencer and request registers
    t_state r_state, n_state;
    t_mode r_mode, n_mode;
    logic [TEXT_W-1:0] r_text, n_text;

    // Queue pointers and line state
    logic [SW-1:0] r_wslot, n_wslot;
    logic [SW-1:0] r_rslot, n_rslot;
    logic [FW-1:0] r_fill, n_fill;
    logic r_open, n_open;
    logic r_abort, n_abort;
    logic [TYPE_W-1:0] r_open_type, n_open_type;
    logic [CW-1:0] r_open_total, n_open_total;
    logic [FW-1:0] r_line_added, n_line_added;

    // Copy and pop counters
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_wr_pend, n_wr_pend;
    logic [CW-1:0] r_wr_idx, n_wr_idx;
    logic [SW-1:0] r_pslot, n_pslot;
    logic [TYPE_W-1:0] r_ptype, n_ptype;
    logic [CW-1:0] r_pn, n_pn;

    // Result registers
    logic r_valid, n_valid;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [TYPE_W-1:0] r_cmd_type, n_cmd_type;
    logic [TOK_W-1:0] r_token_out, n_token_out;
    logic [IDX_W-1:0] r_token_index, n_token_index;
    logic [TOTAL_W-1:0] r_tokens_in_cmd, n_tokens_in_cmd;
    logic r_last, n_last;
    logic [COUNT_W-1:0] r_added, n_added;
    logic [COUNT_W-1:0] r_qfill, n_qfill;

    // Memory ports
    logic open_we, open_re;
    logic [OIW-1:0] open_waddr, open_raddr;
    logic [TOK_W-1:0] open_wdata, open_rdata;
    logic meta_we, meta_re;
    logic [SW-1:0] meta_waddr, meta_raddr;
    logic [MW-1:0] meta_wdata, meta_rdata;
    logic store_we, store_re;
    logic [AW-1:0] store_waddr, store_raddr;
    logic [TOK_W-1:0] store_rdata;

    // Decode terms
    logic w_is_cmd, w_full, w_tok_push, w_eol_push, w_push_done, w_pop_last;
    logic [TYPE_W-1:0] w_class;
    logic [TOK_W-1:0] w_stored;
    logic [CW-1:0] w_meta_total;
    logic [AW-1:0] w_wbase, w_pbase;

    assign w_is_cmd = is_cmd_letter(r_text[7:0]);
    assign w_full = (r_fill >= FW'(RING_ENTRIES));
    assign w_class = classify(r_text);
    assign w_stored = stored_form(r_text, TOKEN_CHARS - 1);
    assign w_tok_push = !r_abort && w_is_cmd && r_open && !w_full;
    assign w_eol_push = !r_abort && r_open && !w_full;
    assign w_push_done = ((r_cnt + 1'b1) == r_open_total);
    assign w_pop_last = ((CW + 1)'(r_cnt) + 1'b1 >= (CW + 1)'(r_pn));
    assign w_meta_total = meta_rdata[CW-1:0];
    assign w_wbase = AW'(r_wslot) * AW'(TOKENS_PER_COMMAND);
    assign w_pbase = AW'(r_pslot) * AW'(TOKENS_PER_COMMAND);

    // Copy write comes in the cycle after the open-buffer read
    assign store_we = r_wr_pend;
    assign store_waddr = w_wbase + AW'(r_wr_idx);

    gcsq_ram #(
        .WIDTH(TOK_W),
        .DEPTH(TOKENS_PER_COMMAND)
    ) u_open_ram (
        .i_clk   (i_clk),
        .i_we    (open_we),
        .i_waddr (open_waddr),
        .i_wdata (open_wdata),
        .i_re    (open_re),
        .i_raddr (open_raddr),
        .o_rdata (open_rdata)
    );

    gcsq_ram #(
        .WIDTH(MW),
        .DEPTH(RING_ENTRIES)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_re    (meta_re),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    gcsq_ram #(
        .WIDTH(TOK_W),
        .DEPTH(STORE_DEPTH)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (open_rdata),
        .i_re    (store_re),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_mode)
                    MODE_TOKEN: n_state = w_tok_push ? S_PUSH : S_IDLE;
                    MODE_EOL:   n_state = w_eol_push ? S_PUSH : S_REPORT;
                    MODE_POP:   n_state = (r_fill == '0) ? S_IDLE : S_POP_META;
                    MODE_CLEAR: n_state = S_IDLE;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_PUSH: begin
                if (w_push_done) begin
                    n_state = S_PUSH_LAST;
                end
            end
            S_PUSH_LAST: begin
                n_state = (r_mode == MODE_EOL) ? S_REPORT : S_IDLE;
            end
            S_REPORT: begin
                n_state = S_IDLE;
            end
            S_POP_META: begin
                n_state = S_POP;
            end
            S_POP: begin
                if (w_pop_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath, memory control and results
    always_comb begin
        n_mode = r_mode;
        n_text = r_text;
        n_wslot = r_wslot;
        n_rslot = r_rslot;
        n_fill = r_fill;
        n_open = r_open;
        n_abort = r_abort;
        n_open_type = r_open_type;
        n_open_total = r_open_total;
        n_line_added = r_line_added;
        n_cnt = r_cnt;
        n_wr_pend = 1'b0;
        n_wr_idx = r_wr_idx;
        n_pslot = r_pslot;
        n_ptype = r_ptype;
        n_pn = r_pn;
        n_valid = 1'b0;
        n_kind = r_kind;
        n_cmd_type = r_cmd_type;
        n_token_out = r_token_out;
        n_token_index = r_token_index;
        n_tokens_in_cmd = r_tokens_in_cmd;
        n_last = r_last;
        n_added = r_added;
        n_qfill = r_qfill;
        open_we = 1'b0;
        open_waddr = '0;
        open_wdata = w_stored;
        open_re = 1'b0;
        open_raddr = OIW'(r_cnt);
        meta_we = 1'b0;
        meta_waddr = r_wslot;
        meta_wdata = {r_open_type, r_open_total};
        meta_re = 1'b0;
        meta_raddr = r_rslot;
        store_re = 1'b0;
        store_raddr = w_pbase + AW'(r_cnt) + 1'b1;

        unique case (r_state)
            S_IDLE: begin
                // Take the request
                if (start) begin
                    n_mode = t_mode'(i_mode);
                    n_text = i_token_text & TEXT_MASK;
                end
            end
            S_DECODE: begin
                n_cnt = '0;
                unique case (r_mode)
                    MODE_TOKEN: begin
                        if (!r_abort && w_is_cmd) begin
                            if (r_open && w_full) begin
                                // Ring full: drop both commands and the rest of the line
                                n_abort = 1'b1;
                                n_open = 1'b0;
                            end else if (!r_open) begin
                                n_open = 1'b1;
                                n_open_type = w_class;
                                n_open_total = CW'(1);
                                open_we = 1'b1;
                            end
                        end else if (!r_abort && r_open &&
                                     r_open_total < CW'(TOKENS_PER_COMMAND)) begin
                            // Append argument token
                            open_we = 1'b1;
                            open_waddr = OIW'(r_open_total);
                            n_open_total = r_open_total + 1'b1;
                        end
                    end
                    MODE_EOL: begin
                    end
                    MODE_POP: begin
                        if (r_fill == '0) begin
                            n_valid = 1'b1;
                            n_kind = KIND_EMPTY;
                            n_cmd_type = '0;
                            n_token_out = '0;
                            n_token_index = '0;
                            n_tokens_in_cmd = '0;
                            n_last = 1'b1;
                            n_added = '0;
                            n_qfill = COUNT_W'(r_fill);
                        end else begin
                            // Fetch the header and retire the slot
                            meta_re = 1'b1;
                            n_pslot = r_rslot;
                            n_rslot = (r_rslot == SW'(RING_ENTRIES - 1)) ? '0 : r_rslot + 1'b1;
                            n_fill = r_fill - 1'b1;
                        end
                    end
                    MODE_CLEAR: begin
                        n_wslot = '0;
                        n_rslot = '0;
                        n_fill = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_PUSH: begin
                // Read one open token per cycle; its store write follows
                open_re = 1'b1;
                n_wr_pend = 1'b1;
                n_wr_idx = r_cnt;
                n_cnt = r_cnt + 1'b1;
            end
            S_PUSH_LAST: begin
                meta_we = 1'b1;
                n_wslot = (r_wslot == SW'(RING_ENTRIES - 1)) ? '0 : r_wslot + 1'b1;
                n_fill = r_fill + 1'b1;
                n_line_added = r_line_added + 1'b1;
                if (r_mode == MODE_TOKEN) begin
                    // Open the command that closed the previous one
                    n_open = 1'b1;
                    n_open_type = w_class;
                    n_open_total = CW'(1);
                    open_we = 1'b1;
                end
            end
            S_REPORT: begin
                n_valid = 1'b1;
                n_kind = KIND_EOL;
                n_cmd_type = '0;
                n_token_out = '0;
                n_token_index = '0;
                n_tokens_in_cmd = '0;
                n_last = 1'b1;
                n_added = COUNT_W'(r_line_added);
                n_qfill = COUNT_W'(r_fill);
                n_open = 1'b0;
                n_abort = 1'b0;
                n_open_type = '0;
                n_open_total = '0;
                n_line_added = '0;
            end
            S_POP_META: begin
                n_ptype = meta_rdata[MW-1:CW];
                n_pn = (w_meta_total > CW'(TOKENS_PER_COMMAND)) ?
                       CW'(TOKENS_PER_COMMAND) : w_meta_total;
                store_re = 1'b1;
                store_raddr = w_pbase;
                n_cnt = '0;
            end
            S_POP: begin
                // Emit one token and prefetch the next
                n_valid = 1'b1;
                n_kind = KIND_TOKEN;
                n_cmd_type = r_ptype;
                n_token_out = (r_pn == '0) ? '0 : store_rdata;
                n_token_index = IDX_W'(r_cnt);
                n_tokens_in_cmd = TOTAL_W'(r_pn);
                n_last = w_pop_last;
                n_added = '0;
                n_qfill = COUNT_W'(r_fill);
                store_re = !w_pop_last;
                n_cnt = r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wslot <= '0;
            r_rslot <= '0;
            r_fill <= '0;
            r_open <= 1'b0;
            r_abort <= 1'b0;
            r_open_type <= '0;
            r_open_total <= '0;
            r_line_added <= '0;
            r_wr_pend <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wslot <= n_wslot;
            r_rslot <= n_rslot;
            r_fill <= n_fill;
            r_open <= n_open;
            r_abort <= n_abort;
            r_open_type <= n_open_type;
            r_open_total <= n_open_total;
            r_line_added <= n_line_added;
            r_wr_pend <= n_wr_pend;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_text <= n_text;
        r_cnt <= n_cnt;
        r_wr_idx <= n_wr_idx;
        r_pslot <= n_pslot;
        r_ptype <= n_ptype;
        r_pn <= n_pn;
        r_kind <= n_kind;
        r_cmd_type <= n_cmd_type;
        r_token_out <= n_token_out;
        r_token_index <= n_token_index;
        r_tokens_in_cmd <= n_tokens_in_cmd;
        r_last <= n_last;
        r_added <= n_added;
        r_qfill <= n_qfill;
    end

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_kind = r_kind;
    assign o_cmd_type = r_cmd_type;
    assign o_token_out = r_token_out;
    assign o_token_index = r_token_index;
    assign o_tokens_in_command = r_tokens_in_cmd;
    assign o_last = r_last;
    assign o_added_in_line = r_added;
    assign o_queue_fill = r_qfill;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(RING_ENTRIES))
        else $error("queue fill above ring size");

    a_push_has_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> (r_open && r_open_total != '0))
        else $error("push without an open command");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result after end of run");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken without going busy");
`endif

endmodule

/* verif/gcode_command_splitter_queue_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for gcode_command_splitter_queue: directed and random G-code lines,
// pops and clears, with every result checked against a local model of the command queue.
// Depends on gcsq_pkg and the gcode_command_splitter_queue RTL.

module gcode_command_splitter_queue_tb;
    import gcsq_pkg::*;

    localparam int unsigned RING_DEPTH = DEF_RING_ENTRIES;
    localparam int unsigned CMD_TOKENS = DEF_TOKENS_PER_CMD;
    localparam int unsigned IDLE_PCT = 22;
    localparam int unsigned WATCHDOG_LIMIT = 600;
    localparam int unsigned TAIL_CYCLES = 16;
    localparam int unsigned REQUEST_TARGET = 210;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TYPE_W-1:0]  cmd_type;
        logic [TOK_W-1:0]   token;
        logic [IDX_W-1:0]   token_idx;
        logic [TOTAL_W-1:0] token_cnt;
        logic               last;
        logic [COUNT_W-1:0] added;
        logic [COUNT_W-1:0] fill;
    } t_cmd_result;

    // DUT connections, all inputs known from time zero
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [MODE_W-1:0]    i_mode = MODE_TOKEN;
    logic [TEXT_W-1:0]    i_token_text = '0;
    logic                 o_valid;
    logic [KIND_W-1:0]    o_kind;
    logic [TYPE_W-1:0]    o_cmd_type;
    logic [TOK_W-1:0]     o_token_out;
    logic [IDX_W-1:0]     o_token_index;
    logic [TOTAL_W-1:0]   o_tokens_in_command;
    logic                 o_last;
    logic [COUNT_W-1:0]   o_added_in_line;
    logic [COUNT_W-1:0]   o_queue_fill;

    // Command number tables, position gives the dense code
    int unsigned g_numbers [15] = '{0, 1, 2, 3, 4, 17, 18, 19, 20, 21, 28, 30, 90, 91, 92};
    int unsigned m_numbers [10] = '{0, 1, 2, 3, 4, 5, 7, 8, 9, 30};

    // Model of the command queue and the line under construction
    logic [TYPE_W-1:0]           ring_code [RING_DEPTH];
    logic [TOTAL_W-1:0]          ring_count [RING_DEPTH];
    logic [TOK_W-1:0]            ring_tokens [RING_DEPTH][CMD_TOKENS];
    logic [$clog2(RING_DEPTH)-1:0] wr_ptr = '0;
    logic [$clog2(RING_DEPTH)-1:0] rd_ptr = '0;
    int unsigned                 ring_fill = 0;
    bit                          line_open = 1'b0;
    bit                          line_abort = 1'b0;
    logic [TYPE_W-1:0]           open_code = '0;
    int unsigned                 open_count = 0;
    logic [TOK_W-1:0]            open_buf [CMD_TOKENS];
    int unsigned                 line_pushes = 0;

    t_cmd_result pending_cmd_results [$];
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned requests_sent = 0;
    bit          idle_en = 1'b1;

    gcode_command_splitter_queue uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_mode              (i_mode),
        .i_token_text        (i_token_text),
        .o_valid             (o_valid),
        .o_kind              (o_kind),
        .o_cmd_type          (o_cmd_type),
        .o_token_out         (o_token_out),
        .o_token_index       (o_token_index),
        .o_tokens_in_command (o_tokens_in_command),
        .o_last              (o_last),
        .o_added_in_line     (o_added_in_line),
        .o_queue_fill        (o_queue_fill)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- model

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ? c - CHAR_CASE_GAP : c;
    endfunction

    function automatic logic [7:0] text_byte(input logic [TEXT_W-1:0] text,
                                             input int unsigned pos);
        if (pos >= TEXT_W / 8) begin
            return 8'h00;
        end
        return text[8*pos +: 8];
    endfunction

    function automatic bit is_cmd_token(input logic [TEXT_W-1:0] text);
        return upcase(text[7:0]) == CHAR_G || upcase(text[7:0]) == CHAR_M;
    endfunction

    // Keep the characters before the first NUL, one fewer than the token holds
    function automatic logic [TOK_W-1:0] keep_prefix(input logic [TEXT_W-1:0] text);
        logic [TOK_W-1:0] kept;
        bit ended;
        kept = '0;
        ended = 1'b0;
        for (int i = 0; i < TOK_W / 8; i++) begin
            if (text[8*i +: 8] == 8'h00) begin
                ended = 1'b1;
            end
            if (!ended) begin
                kept[8*i +: 8] = text[8*i +: 8];
            end
        end
        return kept;
    endfunction

    // Dense code from the letter and the signed decimal after it
    function automatic logic [TYPE_W-1:0] decode_cmd_code(input logic [TEXT_W-1:0] text);
        logic [7:0] lead;
        logic [7:0] ch;
        int unsigned pos;
        int unsigned number;
        int unsigned ndigits;
        bit minus;
        logic [TYPE_W-1:0] code;
        lead = upcase(text[7:0]);
        pos = 1;
        number = 0;
        ndigits = 0;
        minus = 1'b0;
        code = '0;
        ch = text_byte(text, pos);
        // skip blanks between letter and number
        while (ch == CHAR_SPACE || (ch >= CHAR_TAB && ch <= CHAR_CR)) begin
            pos++;
            ch = text_byte(text, pos);
        end
        if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
            minus = (ch == CHAR_MINUS);
            pos++;
            ch = text_byte(text, pos);
        end
        // accumulate digits, saturating at the ceiling
        while (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            number = number * 10 + (ch - CHAR_ZERO);
            if (number > NUM_CEIL) begin
                number = NUM_CEIL;
            end
            ndigits++;
            pos++;
            ch = text_byte(text, pos);
        end
        // negative zero stays valid, any other negative is unknown
        if (ndigits != 0 && !(minus && number != 0)) begin
            for (int k = 0; k < 15; k++) begin
                if (lead == CHAR_G && g_numbers[k] == number) begin
                    code = TYPE_W'(k + 1);
                end
            end
            for (int k = 0; k < 10; k++) begin
                if (lead == CHAR_M && m_numbers[k] == number) begin
                    code = TYPE_W'(k + 16);
                end
            end
        end
        return code;
    endfunction

    function automatic t_cmd_result make_result(input logic [KIND_W-1:0] kind,
                                                input logic [TYPE_W-1:0] code,
                                                input logic [TOK_W-1:0] tok,
                                                input int unsigned idx,
                                                input int unsigned cnt,
                                                input logic last,
                                                input int unsigned added);
        t_cmd_result r;
        r = '0;
        r.kind = kind;
        r.cmd_type = code;
        r.token = tok;
        r.token_idx = IDX_W'(idx);
        r.token_cnt = TOTAL_W'(cnt);
        r.last = last;
        r.added = COUNT_W'(added);
        r.fill = COUNT_W'(ring_fill);
        return r;
    endfunction

    // Move the open command into the ring
    function automatic void push_open_cmd();
        ring_code[wr_ptr] = open_code;
        ring_count[wr_ptr] = TOTAL_W'(open_count);
        for (int k = 0; k < CMD_TOKENS; k++) begin
            ring_tokens[wr_ptr][k] = open_buf[k];
        end
        wr_ptr++;
        ring_fill++;
        line_pushes++;
    endfunction

    // Advance the model by one accepted request and queue the results it causes
    function automatic void apply_gcode_request(input t_mode mode,
                                                input logic [TEXT_W-1:0] text);
        logic [TYPE_W-1:0] code;
        int unsigned n;
        logic [$clog2(RING_DEPTH)-1:0] slot;
        case (mode)
            MODE_TOKEN: begin
                if (line_abort) begin
                    // drop everything until end of line
                end else if (is_cmd_token(text)) begin
                    if (line_open && ring_fill >= RING_DEPTH) begin
                        line_abort = 1'b1;
                        line_open = 1'b0;
                    end else begin
                        if (line_open) begin
                            push_open_cmd();
                        end
                        for (int k = 0; k < CMD_TOKENS; k++) begin
                            open_buf[k] = '0;
                        end
                        line_open = 1'b1;
                        open_code = decode_cmd_code(text);
                        open_buf[0] = keep_prefix(text);
                        open_count = 1;
                    end
                end else if (line_open && open_count < CMD_TOKENS) begin
                    open_buf[open_count] = keep_prefix(text);
                    open_count++;
                end
            end
            MODE_EOL: begin
                if (!line_abort && line_open && ring_fill < RING_DEPTH) begin
                    push_open_cmd();
                end
                pending_cmd_results.push_back(make_result(KIND_EOL, '0, '0, 0, 0, 1'b1,
                                                          line_pushes));
                line_open = 1'b0;
                line_abort = 1'b0;
                open_code = '0;
                open_count = 0;
                line_pushes = 0;
            end
            MODE_POP: begin
                if (ring_fill == 0) begin
                    pending_cmd_results.push_back(make_result(KIND_EMPTY, '0, '0, 0, 0,
                                                              1'b1, 0));
                end else begin
                    slot = rd_ptr;
                    code = ring_code[slot];
                    n = ring_count[slot];
                    if (n > CMD_TOKENS) begin
                        n = CMD_TOKENS;
                    end
                    rd_ptr++;
                    ring_fill--;
                    for (int k = 0; k < n; k++) begin
                        pending_cmd_results.push_back(make_result(KIND_TOKEN, code,
                            ring_tokens[slot][k], k, n, (k + 1 == n), 0));
                    end
                end
            end
            default: begin
                // clear touches the queue only, the open line survives
                wr_ptr = '0;
                rd_ptr = '0;
                ring_fill = 0;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input t_cmd_result want,
                                   input t_cmd_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%s at %0t ns: want kind=%0d type=%0d tok=%h idx=%0d n=%0d last=%0d",
                     what, $time, want.kind, want.cmd_type, want.token, want.token_idx,
                     want.token_cnt, want.last);
            $display("    want added=%0d fill=%0d | got kind=%0d type=%0d tok=%h idx=%0d",
                     want.added, want.fill, got.kind, got.cmd_type, got.token, got.token_idx);
            $display("    got n=%0d last=%0d added=%0d fill=%0d",
                     got.token_cnt, got.last, got.added, got.fill);
        end
    endtask

    // Check each strobed result, then feed each accepted request to the model
    always @(posedge i_clk) begin : result_monitor
        t_cmd_result got;
        t_cmd_result want;
        bit taken;
        if (i_rst_n) begin
            taken = (start === 1'b1) && (busy === 1'b0);
            if (o_valid !== 1'b0) begin
                got = {o_kind, o_cmd_type, o_token_out, o_token_index, o_tokens_in_command,
                       o_last, o_added_in_line, o_queue_fill};
                if (pending_cmd_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, got);
                end else begin
                    want = pending_cmd_results.pop_front();
                    if (got !== want || o_valid !== 1'b1) begin
                        report_mismatch("result mismatch", want, got);
                    end
                end
            end
            if (taken) begin
                apply_gcode_request(t_mode'(i_mode), i_token_text);
            end
            stall_cycles = (taken || o_valid === 1'b1) ? 0 : stall_cycles + 1;
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("FAIL gcode_command_splitter_queue");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_request(input t_mode mode, input logic [TEXT_W-1:0] text);
        // hold the request off for a random stretch
        while (idle_en && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_mode       <= mode;
        i_token_text <= text;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        requests_sent++;
    endtask

    // Pause requests until every expected result has come back
    task automatic wait_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_cmd_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [TEXT_W-1:0] pack_text(input string s, input bit junk_tail);
        logic [TEXT_W-1:0] t;
        int n;
        t = '0;
        n = (s.len() < TEXT_W / 8) ? s.len() : TEXT_W / 8;
        for (int i = 0; i < n; i++) begin
            t[8*i +: 8] = s[i];
        end
        // bytes past the terminating NUL are don't-care; fill them with noise
        if (junk_tail) begin
            for (int i = n + 1; i < TEXT_W / 8; i++) begin
                t[8*i +: 8] = 8'($urandom);
            end
        end
        return t;
    endfunction

    task automatic send_text(input string s);
        send_request(MODE_TOKEN, pack_text(s, 1'b0));
    endtask

    function automatic logic [TEXT_W-1:0] random_cmd_token();
        logic [7:0] letter;
        string sign_txt;
        string s;
        int unsigned num;
        bit is_g;
        is_g = $urandom_range(1);
        letter = is_g ? CHAR_G : CHAR_M;
        if ($urandom_range(1)) begin
            letter = letter + CHAR_CASE_GAP;
        end
        case ($urandom_range(11))
            0: sign_txt = " ";
            1: sign_txt = "+";
            2, 3: sign_txt = "-";
            4: sign_txt = "\t";
            5: sign_txt = " -";
            default: sign_txt = "";
        endcase
        case ($urandom_range(9))
            0: num = $urandom_range(1200);
            1: num = $urandom_range(99999);
            default: num = is_g ? g_numbers[$urandom_range(14)] : m_numbers[$urandom_range(9)];
        endcase
        if ($urandom_range(19) == 0) begin
            s = $sformatf("%c%sX", letter, sign_txt);
        end else begin
            s = $sformatf("%c%s%0d", letter, sign_txt, num);
        end
        return pack_text(s, $urandom_range(4) == 0);
    endfunction

    function automatic logic [TEXT_W-1:0] random_param_token();
        string axes;
        string s;
        axes = "XYZFSIJPRxyz";
        case ($urandom_range(11))
            0: return pack_text("", $urandom_range(1));
            1: return {$urandom, $urandom};
            2: s = $sformatf("%c-%0d.%0d", axes[$urandom_range(11)], $urandom_range(999),
                             $urandom_range(999));
            default: s = $sformatf("%c%0d.%0d", axes[$urandom_range(11)],
                                   $urandom_range(9999), $urandom_range(99));
        endcase
        return pack_text(s, $urandom_range(4) == 0);
    endfunction

    // One line: optional stray tokens, n commands with parameters, end of line
    task automatic send_line(input int unsigned n_cmds, input int unsigned max_params,
                             input bit lead_junk);
        if (lead_junk) begin
            repeat ($urandom_range(1, 2)) send_request(MODE_TOKEN, random_param_token());
        end
        repeat (n_cmds) begin
            send_request(MODE_TOKEN, random_cmd_token());
            repeat ($urandom_range(max_params)) send_request(MODE_TOKEN, random_param_token());
        end
        send_request(MODE_EOL, {$urandom, $urandom});
    endtask

    task automatic pop_commands(input int unsigned n);
        repeat (n) send_request(MODE_POP, {$urandom, $urandom});
    endtask

    // ---------------------------------------------------------------- tests

    // Parser corner cases, stray and overflowing tokens, clear inside a line
    task automatic test_directed();
        pop_commands(1);
        send_text("X1");
        send_text("G0");
        send_request(MODE_TOKEN, '1);
        send_request(MODE_TOKEN, '0);
        send_text("g1");
        send_text("M-0");
        send_text("G-1");
        send_text("G+2");
        send_text("G 17");
        send_text("G\t90");
        send_text("G");
        send_text("M99999");
        send_text("G0030");
        send_request(MODE_EOL, '0);
        pop_commands(2);
        // nearly fill one command, clear mid-line, then fill it to capacity and overflow it
        send_text("m30");
        send_text("X10.5");
        send_text("Y-3");
        send_text("Z0.25");
        send_text("F1500");
        send_text("S12000");
        send_text("ABCDEFGH");
        send_request(MODE_CLEAR, '1);
        send_text("P9");
        send_text("Q1");
        send_request(MODE_EOL, '1);
        pop_commands(2);
    endtask

    // Fill the ring, overflow it mid-line and at end of line, then drain it
    task automatic test_queue_overflow();
        send_line(18, 1, 1'b0);
        send_line(2, 1, 1'b0);
        wait_drain();
        pop_commands(1);
        send_line(1, 2, 1'b0);
        send_line(1, 0, 1'b1);
        pop_commands(RING_DEPTH + 1);
    endtask

    // Back-to-back requests with no idle cycles
    task automatic test_back_to_back();
        idle_en = 1'b0;
        repeat (6) begin
            send_line($urandom_range(1, 3), 3, $urandom_range(1));
            pop_commands($urandom_range(1, 3));
        end
        idle_en = 1'b1;
    endtask

    // Mostly well-formed lines and pops, with noise requests and drain pauses
    task automatic test_random_traffic();
        int unsigned pick;
        while (requests_sent < REQUEST_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_line($urandom_range(1, 4), ($urandom_range(4) == 0) ? 9 : 4,
                          $urandom_range(3) == 0);
            end else if (pick < 80) begin
                pop_commands($urandom_range(1, 6));
            end else if (pick < 96) begin
                send_request(t_mode'($urandom_range(3)), {$urandom, $urandom});
            end else begin
                wait_drain();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_queue_overflow();
        test_back_to_back();
        test_random_traffic();
        // let the last request finish and its results arrive
        start <= 1'b0;
        while (pending_cmd_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_cmd_results.size() == 0) begin
            $display("PASS gcode_command_splitter_queue");
        end else begin
            $display("FAIL gcode_command_splitter_queue");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/gcsq_pkg.sv
rtl/gcsq_ram.sv
rtl/gcode_command_splitter_queue.sv
verif/gcode_command_splitter_queue_tb.sv
